FILE: hdl/hfec_pkg.sv
package hfec_pkg;

	// Window and tap geometry
	localparam int MAX_TAPS  = 9;
	localparam int MAX_HALF  = (MAX_TAPS - 1) / 2;
	localparam int HALF_W    = $clog2(MAX_HALF + 1);
	localparam int TAP_IDX_W = $clog2(MAX_TAPS);
	localparam int RES_W     = $clog2(MAX_HALF + 2);

	// Sample, tap and arithmetic widths
	localparam int SMP_W   = 16;
	localparam int PROD_W  = 2 * SMP_W;
	localparam int ACC_W   = PROD_W - 1 + $clog2(MAX_TAPS);
	localparam int DIV_W   = 16;
	localparam int DCNT_W  = $clog2(ACC_W);

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TAPS_LO  = 3'd0,
		REG_TAPS_HI  = 3'd1,
		REG_TAP_8    = 3'd2,
		REG_HALF_W   = 3'd3,
		REG_DIVISOR  = 3'd4
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC,
		ST_TAIL,
		ST_DSETUP,
		ST_DIV,
		ST_EMIT
	} state_t;

endpackage

FILE: hdl/horizontal_fir_edge_clamp.sv
// Each result takes a multiply-accumulate sweep over the 2*w+1 taps of the window, where w is the
// effective half width, then the ST_TAIL and ST_DSETUP states and 35 divide steps, before it
// reaches the output register; a result the output holds back stalls the next one. A word that
// gives no result is taken and the block stays idle; a word giving results holds the block (in_ready
// low) until its last result is emitted, as the shared multiplier and serial divider do one at a time.
// Reset (arst_n low, asynchronous) restores the register defaults.
module horizontal_fir_edge_clamp import hfec_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [SMP_W-1:0]      sample,
	input  logic                         line_end,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [SMP_W-1:0]      filtered,
	output logic                         line_last,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_data
);

	state_t state_q, state_d;

	// Configuration registers
	logic [CFG_DATA_W-1:0]   taps_lo_q, taps_hi_q;
	logic signed [SMP_W-1:0] tap8_q;
	logic [2:0]              hw_q;
	logic [DIV_W-1:0]        divisor_q;

	// Line state
	logic signed [SMP_W-1:0] win_q   [MAX_TAPS];
	logic signed [SMP_W-1:0] win_d   [MAX_TAPS];
	logic signed [SMP_W-1:0] win_up  [MAX_TAPS];
	logic signed [SMP_W-1:0] taps    [MAX_TAPS];
	logic [HALF_W-1:0]       fill_q, fill_d;
	logic [RES_W-1:0]        left_q, nres;
	logic                    flush_q;

	// Shared arithmetic
	logic [TAP_IDX_W-1:0]    idx_q, last_idx;
	logic signed [PROD_W-1:0] prod_s1;
	logic                    pv_s1;
	logic signed [ACC_W-1:0] acc_q;
	logic [ACC_W-1:0]        dvd_q;
	logic [DIV_W-1:0]        rmd_q, dvs_q;
	logic [DCNT_W-1:0]       dcnt_q;
	logic                    neg_q;
	logic [DIV_W:0]          trial;
	logic                    ge;
	logic [DIV_W-1:0]        quo16;

	// Output register
	logic                    out_valid_q;
	logic signed [SMP_W-1:0] filtered_q;
	logic                    line_last_q;

	logic [HALF_W-1:0]       w;
	logic                    early;
	logic                    acc_go, emit_go;

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign filtered  = filtered_q;
	assign line_last = line_last_q;

	// Effective half width and last tap index
	assign w        = (int'(hw_q) > MAX_HALF) ? HALF_W'(MAX_HALF) : HALF_W'(hw_q);
	assign last_idx = TAP_IDX_W'({w, 1'b0});
	assign early    = fill_q < w;

	// Unpack tap weights; taps past the ninth are zero
	always_comb begin
		for (int i = 0; i < MAX_TAPS; i++) begin
			if (i < 4)
				taps[i] = taps_lo_q[16*i +: 16];
			else if (i < 8)
				taps[i] = taps_hi_q[16*(i-4) +: 16];
			else if (i == 8)
				taps[i] = tap8_q;
			else
				taps[i] = '0;
		end
	end

	// Window advanced by one place
	always_comb begin
		for (int i = 0; i < MAX_TAPS - 1; i++)
			win_up[i] = win_q[i+1];
		win_up[MAX_TAPS-1] = win_q[MAX_TAPS-1];
	end

	// Results caused by the incoming word, and the next fill count
	always_comb begin
		if (line_end) begin
			nres   = early ? RES_W'(fill_q) + RES_W'(1) : RES_W'(w) + RES_W'(1);
			fill_d = '0;
		end else if (early) begin
			nres   = '0;
			fill_d = fill_q + HALF_W'(1);
		end else begin
			nres   = RES_W'(1);
			fill_d = fill_q;
		end
	end

	// Sequencer: next state and handshake
	always_comb begin
		in_ready = (state_q == ST_IDLE);
		acc_go   = in_valid && in_ready;
		emit_go  = (state_q == ST_EMIT) && (!out_valid_q || out_ready);
		state_d  = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc_go && nres != '0)
					state_d = ST_MAC;
			end
			ST_MAC: begin
				if (idx_q == last_idx)
					state_d = ST_TAIL;
			end
			ST_TAIL:   state_d = ST_DSETUP;
			ST_DSETUP: state_d = ST_DIV;
			ST_DIV: begin
				if (dcnt_q == '0)
					state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (emit_go)
					state_d = (left_q == RES_W'(1)) ? ST_IDLE : ST_MAC;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// Window update: load the new word with edge clamping, or advance after a result
	always_comb begin
		for (int i = 0; i < MAX_TAPS; i++) begin
			win_d[i] = win_q[i];
			if (acc_go) begin
				if (fill_q == '0 && i < int'(w))
					win_d[i] = sample;
				if (early) begin
					if (i == int'(w) + int'(fill_q))
						win_d[i] = sample;
					if (line_end && i > int'(w) + int'(fill_q) && i <= 2 * int'(w))
						win_d[i] = sample;
				end else if (i == 2 * int'(w)) begin
					win_d[i] = sample;
				end
			end else if (emit_go && i < 2 * int'(w)) begin
				win_d[i] = win_up[i];
			end
		end
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taps_lo_q <= CFG_DATA_W'(1);
			taps_hi_q <= '0;
			tap8_q    <= '0;
			hw_q      <= '0;
			divisor_q <= DIV_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_TAPS_LO: taps_lo_q <= cfg_data;
				REG_TAPS_HI: taps_hi_q <= cfg_data;
				REG_TAP_8:   tap8_q    <= cfg_data[SMP_W-1:0];
				REG_HALF_W:  hw_q      <= cfg_data[2:0];
				REG_DIVISOR: divisor_q <= cfg_data[DIV_W-1:0];
				default: ;
			endcase
		end
	end

	// Line state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_TAPS; i++)
				win_q[i] <= '0;
			fill_q      <= '0;
			left_q      <= '0;
			flush_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			win_q <= win_d;
			if (acc_go) begin
				fill_q  <= fill_d;
				left_q  <= nres;
				flush_q <= line_end;
			end else if (emit_go) begin
				left_q <= left_q - RES_W'(1);
			end
			if (emit_go)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// Divider step: shift in one dividend bit, subtract when it fits
	assign trial = {rmd_q, dvd_q[ACC_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign quo16 = dvd_q[SMP_W-1:0];

	// Shared multiply-accumulate and serial divide
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_MAC: begin
				prod_s1 <= PROD_W'(win_q[idx_q]) * PROD_W'(taps[idx_q]);
				pv_s1   <= 1'b1;
				if (pv_s1)
					acc_q <= acc_q + ACC_W'(prod_s1);
				idx_q <= idx_q + TAP_IDX_W'(1);
			end
			ST_TAIL: begin
				acc_q <= acc_q + ACC_W'(prod_s1);
			end
			ST_DSETUP: begin
				neg_q  <= acc_q[ACC_W-1];
				dvd_q  <= acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
				rmd_q  <= '0;
				dvs_q  <= (divisor_q == '0) ? DIV_W'(1) : divisor_q;
				dcnt_q <= DCNT_W'(ACC_W - 1);
			end
			ST_DIV: begin
				rmd_q  <= ge ? DIV_W'(trial - {1'b0, dvs_q}) : DIV_W'(trial);
				dvd_q  <= {dvd_q[ACC_W-2:0], ge};
				dcnt_q <= dcnt_q - DCNT_W'(1);
			end
			default: ;
		endcase
		// restart the tap sweep for the next result
		if (state_d == ST_MAC && state_q != ST_MAC) begin
			idx_q <= '0;
			acc_q <= '0;
			pv_s1 <= 1'b0;
		end
		if (emit_go) begin
			filtered_q  <= neg_q ? SMP_W'(SMP_W'(0) - quo16) : quo16;
			line_last_q <= flush_q && (left_q == RES_W'(1));
		end
	end

`ifndef SYNTHESIS
	a_fill_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		int'(fill_q) <= MAX_HALF)
		else $error("fill count beyond the largest half width");

	a_busy_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (left_q != '0))
		else $error("sequencer busy with no result pending");

	a_idx_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MAC) |-> (idx_q <= last_idx))
		else $error("tap index past the window");

	a_rmd_below_dvs: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rmd_q < dvs_q))
		else $error("partial remainder not below divisor");

	a_div_to_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && dcnt_q == '0) |=> (state_q == ST_EMIT))
		else $error("divide did not finish into emit");
`endif

endmodule
